### hdl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// shared constants and types for the grid bilinear sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int NROW_W  = $clog2(MAX_ROWS + 1);
  localparam int NCOL_W  = $clog2(MAX_COLS + 1);
  localparam int ADDR_W  = $clog2(MAX_ROWS * MAX_COLS);

  localparam int TIME_W  = 32;
  localparam int POS_W   = 24;
  localparam int SP_W    = 16;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CNT_W   = 9;

  // quotient of (pos << 16) / spacing: cell index above, fraction below
  localparam int QUO_W     = POS_W + FRAC_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] REG_X_SPACING = 2'd0;
  localparam logic [1:0] REG_Z_SPACING = 2'd1;
  localparam logic [1:0] REG_COLUMNS   = 2'd2;
  localparam logic [1:0] REG_ROWS      = 2'd3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] pos;
    logic [SP_W-1:0]  spacing;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

### hdl/gbs_div.sv
// ----------------------------------------------------------------------------
// gbs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gbs_div
  import gbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [QUO_W-1:0]  quo;
  logic [SP_W-1:0]   rem;
  logic [SP_W-1:0]   divisor;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [SP_W:0]     rem_shift;
  logic              fits;

  assign rem_shift = {rem, quo[QUO_W-1]};
  assign fits      = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= {req.pos, FRAC_W'(0)};
      rem     <= '0;
      // a spacing of zero acts as one
      divisor <= (req.spacing == '0) ? SP_W'(1) : req.spacing;
    end else if (busy) begin
      rem <= fits ? SP_W'(rem_shift - {1'b0, divisor}) : rem_shift[SP_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

### hdl/gbs_mul.sv
// ----------------------------------------------------------------------------
// gbs_mul
// shared 32 x 32 multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gbs_mul
  import gbs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [TIME_W-1:0]   a,
  input  wire logic [TIME_W-1:0]   b,
  output logic      [2*TIME_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {TIME_W'(0), a} * {TIME_W'(0), b};
  end

endmodule
`default_nettype wire

### hdl/gbs_mem.sv
// ----------------------------------------------------------------------------
// gbs_mem
// travel time store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gbs_mem
  import gbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [TIME_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] store [MAX_ROWS*MAX_COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule
`default_nettype wire

### hdl/grid_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// grid_bilinear_sampler
// bilinear sampling of a stored travel time grid
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | kind row col time_value x_pos z_pos
//  out     | out_valid / out_stall| travel_time out_of_grid
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data
//
//  a write goes straight to the grid store; a query runs two 40 step
//  divisions on the shared divider, then the ADDR, WGT and ACC states per
//  corner on the shared multiplier and single read port, plus the output load
//  reset is synchronous; the grid content is undefined until written
//  a finished result waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grid_bilinear_sampler
  import gbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              kind,
  input  wire logic [7:0]        row,
  input  wire logic [7:0]        col,
  input  wire logic [TIME_W-1:0] time_value,
  input  wire logic [POS_W-1:0]  x_pos,
  input  wire logic [POS_W-1:0]  z_pos,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [TIME_W-1:0] travel_time,
  output logic                   out_of_grid,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIVX = 8'b0000_0010,
    S_DIVZ = 8'b0000_0100,
    S_ADDR = 8'b0000_1000,
    S_WGT  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_DONE = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [SP_W-1:0]  x_pitch, z_pitch;
  logic [CNT_W-1:0] grid_columns, grid_rows;

  logic [POS_W-1:0]  z_hold;
  logic [QUO_W-1:0]  qx, qz;
  logic [1:0]        corner;
  logic [2*TIME_W-1:0] acc;
  logic [TIME_W-1:0] gdata;
  logic              whi;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [TIME_W-1:0]   mul_a, mul_b;
  logic [2*TIME_W-1:0] mul_p;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [TIME_W-1:0] mem_rdata;

  logic              in_take, query_take;

  // effective counts and cell location
  logic [NCOL_W-1:0] ncol;
  logic [NROW_W-1:0] nrow;
  logic [COL_W-1:0]  ncol_m1, c1, c2;
  logic [ROW_W-1:0]  nrow_m1, r1, r2;
  logic [POS_W-1:0]  cellx, cellz;
  logic              clampx, clampz;
  logic [FRAC_W-1:0] fx, fz;
  logic [FRAC_W:0]   wx, wz;
  logic [COL_W-1:0]  c_sel;
  logic [ROW_W-1:0]  r_sel;
  logic [2*TIME_W-1:0] rounded;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pitch      <= SP_W'(256);
      z_pitch      <= SP_W'(256);
      grid_columns <= CNT_W'(256);
      grid_rows    <= CNT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_SPACING: x_pitch      <= cfg_data;
        REG_Z_SPACING: z_pitch      <= cfg_data;
        REG_COLUMNS:   grid_columns <= cfg_data[CNT_W-1:0];
        REG_ROWS:      grid_rows    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign query_take = in_take && (kind == KIND_QUERY);

  always_comb begin
    if (grid_columns == '0) begin
      ncol = NCOL_W'(1);
    end else if (32'(grid_columns) > MAX_COLS) begin
      ncol = NCOL_W'(MAX_COLS);
    end else begin
      ncol = NCOL_W'(grid_columns);
    end
    if (grid_rows == '0) begin
      nrow = NROW_W'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      nrow = NROW_W'(MAX_ROWS);
    end else begin
      nrow = NROW_W'(grid_rows);
    end
    ncol_m1 = COL_W'(ncol - 1'b1);
    nrow_m1 = ROW_W'(nrow - 1'b1);

    cellx  = qx[QUO_W-1:FRAC_W];
    cellz  = qz[QUO_W-1:FRAC_W];
    clampx = cellx >= POS_W'(ncol);
    clampz = cellz >= POS_W'(nrow);

    // upper corner on the last sample repeats it
    if (clampx) begin
      c1 = ncol_m1;
      c2 = ncol_m1;
      fx = '0;
    end else begin
      c1 = cellx[COL_W-1:0];
      c2 = (cellx[COL_W-1:0] == ncol_m1) ? ncol_m1 : COL_W'(cellx + 1'b1);
      fx = qx[FRAC_W-1:0];
    end
    if (clampz) begin
      r1 = nrow_m1;
      r2 = nrow_m1;
      fz = '0;
    end else begin
      r1 = cellz[ROW_W-1:0];
      r2 = (cellz[ROW_W-1:0] == nrow_m1) ? nrow_m1 : ROW_W'(cellz + 1'b1);
      fz = qz[FRAC_W-1:0];
    end

    c_sel = corner[0] ? c2 : c1;
    r_sel = corner[1] ? r2 : r1;
    wx    = corner[0] ? {1'b0, fx} : ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, fx};
    wz    = corner[1] ? {1'b0, fz} : ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, fz};
  end

  // grid store
  assign mem_we    = in_take && (kind == KIND_WRITE) &&
                     (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
  assign mem_waddr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  assign mem_raddr = ADDR_W'(r_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(c_sel);

  gbs_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (time_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // divider shared by both axes
  always_comb begin
    div_req.start   = 1'b0;
    div_req.pos     = x_pos;
    div_req.spacing = x_pitch;
    if (state == S_IDLE) begin
      div_req.start = query_take;
    end else if (state == S_DIVX) begin
      div_req.start   = div_rsp.done;
      div_req.pos     = z_hold;
      div_req.spacing = z_pitch;
    end
  end

  gbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // weight product first, then sample times weight
  always_comb begin
    if (state == S_ADDR) begin
      mul_a = TIME_W'(wx);
      mul_b = TIME_W'(wz);
    end else begin
      mul_a = mem_rdata;
      mul_b = mul_p[TIME_W-1:0];
    end
  end

  gbs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (query_take) state_next = S_DIVX;
      S_DIVX: if (div_rsp.done) state_next = S_DIVZ;
      S_DIVZ: if (div_rsp.done) state_next = S_ADDR;
      S_ADDR: state_next = S_WGT;
      S_WGT:  state_next = S_ACC;
      S_ACC:  state_next = (corner == 2'd3) ? S_DONE : S_ADDR;
      S_DONE: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      corner <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIVZ) begin
        corner <= '0;
      end else if (state == S_ACC && corner != 2'd3) begin
        corner <= corner + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_take) begin
      z_hold <= z_pos;
    end
    if (state == S_DIVX && div_rsp.done) begin
      qx <= div_rsp.quotient;
    end
    if (state == S_DIVZ && div_rsp.done) begin
      qz  <= div_rsp.quotient;
      acc <= '0;
    end
    if (state == S_WGT) begin
      gdata <= mem_rdata;
      whi   <= mul_p[TIME_W];
    end
    if (state == S_ACC) begin
      // a full weight of 2^32 has zero low bits, so the product is zero
      acc <= acc + (whi ? {gdata, TIME_W'(0)} : mul_p);
    end
  end

  assign rounded = acc + (2*TIME_W)'(64'h8000_0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      travel_time <= rounded[2*TIME_W-1:TIME_W];
      out_of_grid <= clampx || clampz;
    end
  end

`ifndef SYNTH
  a_query_starts_div: assert property (@(posedge clk) disable iff (rst)
    query_take |=> (state == S_DIVX) && div_rsp.busy)
    else $error("query did not start the x division");

  a_div_in_div_states: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> (state == S_DIVX || state == S_DIVZ))
    else $error("divider busy outside a division state");

  a_all_corners: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (corner == 2'd3))
    else $error("result loaded before all four corners");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the done state");
`endif

endmodule
`default_nettype wire
